FILE: sv/wsdf_pkg.sv
`timescale 1ns / 1ps
package wsdf_pkg;

  typedef enum logic [1:0] {
    KindData   = 2'd0,
    KindEmpty  = 2'd1,
    KindReject = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ErrNone  = 2'd0,
    ErrTrunc = 2'd1,
    ErrFin   = 2'd2,
    ErrLen64 = 2'd3
  } err_e;

  localparam logic [6:0] LenCodeExt16 = 7'd126;
  localparam logic [6:0] LenCodeExt64 = 7'd127;
  localparam int unsigned MaskKeyBytes = 4;
  localparam int unsigned MaskCntW = $clog2(MaskKeyBytes);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW = $clog2(FifoDepth);
  localparam int unsigned FifoCntW = $clog2(FifoDepth + 1);

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [3:0] opcode;
    logic       last_of_frame;
    err_e       error_code;
  } res_t;

  // handshake between the parser and the result queue
  typedef struct packed {
    logic push;
    res_t item;
  } push_t;

endpackage

FILE: sv/wsdf_if.sv
`timescale 1ns / 1ps
interface wsdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface wsdf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [3:0] opcode;
  logic       last_of_frame;
  logic [1:0] error_code;

  modport source (
    output valid, output kind, output payload_byte, output opcode,
    output last_of_frame, output error_code, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input opcode,
    input last_of_frame, input error_code, output ready
  );
endinterface

FILE: sv/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// websocket frame deframer
// in_i carries one received byte per word with buffer_end set on the
// buffer's final byte; every buffer begins a new frame. out_o carries one
// result word per payload byte (kind data, raw mask-free copy, opcode, last
// flag), one empty-frame completion word, or one rejection word with its
// error code. Header, mask key and trailing bytes give no data word.
// Throughput: one byte per cycle in, one word per cycle out, while the queue
// has room and out_o.ready is high. The header parser updates its state once
// per accepted byte and pushes into a four-entry result queue; an output
// register drains the queue. A byte's word is written into the queue, then
// loaded into the output register that drives out_o.
// Stall: when out_o.ready is low the output register holds its word, the
// queue fills and in_i.ready drops once four words wait behind it.
// Reset (rst_ni low, asynchronous) empties the queue and output register and
// returns the parser to expecting a frame's first byte.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsdf_in_if.sink     in_i,
  wsdf_out_if.source  out_o
);

  wsdf_pkg::push_t  push;
  wsdf_pkg::res_t   head;
  wsdf_pkg::res_t   out_word;
  logic             full;
  logic             empty;
  logic             pop;

  wsdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .data_byte_i  (in_i.data_byte),
    .buffer_end_i (in_i.buffer_end),
    .full_i       (full),
    .in_ready_o   (in_i.ready),
    .push_o       (push)
  );

  wsdf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  wsdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .out_ready_i (out_o.ready),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_word_o  (out_word)
  );

  assign out_o.kind          = out_word.kind;
  assign out_o.payload_byte  = out_word.payload_byte;
  assign out_o.opcode        = out_word.opcode;
  assign out_o.last_of_frame = out_word.last_of_frame;
  assign out_o.error_code    = out_word.error_code;

endmodule

FILE: sv/wsdf_front.sv
`timescale 1ns / 1ps
module wsdf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       data_byte_i,
  input  logic             buffer_end_i,
  input  logic             full_i,
  output logic             in_ready_o,
  output wsdf_pkg::push_t  push_o
);

  typedef enum logic [2:0] {
    PhFirst   = 3'd0,
    PhSecond  = 3'd1,
    PhFinBad  = 3'd2,
    PhExtHi   = 3'd3,
    PhExtLo   = 3'd4,
    PhMask    = 3'd5,
    PhPayload = 3'd6,
    PhDone    = 3'd7
  } phase_e;

  phase_e                         phase_q, phase_d;
  logic [wsdf_pkg::MaskCntW-1:0]  hcnt_q, hcnt_d;
  logic [3:0]                     opcode_q, opcode_d;
  logic                           mask_q, mask_d;
  logic [15:0]                    len_q, len_d;
  logic [15:0]                    rem_q, rem_d;

  logic             accept;
  logic             emit;
  wsdf_pkg::res_t   res;
  logic             after_len;
  logic [15:0]      len_new;
  logic             mask_new;
  logic [7:0]       b;
  logic             fin_end;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign b          = data_byte_i;
  assign fin_end    = buffer_end_i;

  always_comb begin
    phase_d   = phase_q;
    hcnt_d    = hcnt_q;
    opcode_d  = opcode_q;
    mask_d    = mask_q;
    len_d     = len_q;
    rem_d     = rem_q;
    emit      = 1'b0;
    after_len = 1'b0;
    len_new   = len_q;
    mask_new  = mask_q;
    res.kind          = wsdf_pkg::KindReject;
    res.payload_byte  = 8'h00;
    res.opcode        = opcode_q;
    res.last_of_frame = 1'b0;
    res.error_code    = wsdf_pkg::ErrTrunc;

    unique case (phase_q)
      PhFirst: begin
        opcode_d = b[3:0];
        mask_d   = 1'b0;
        len_d    = 16'h0000;
        rem_d    = 16'h0000;
        hcnt_d   = '0;
        res.opcode = b[3:0];
        if (fin_end) begin
          emit = 1'b1;
        end else begin
          phase_d = b[7] ? PhSecond : PhFinBad;
        end
      end
      PhFinBad: begin
        emit           = 1'b1;
        res.error_code = wsdf_pkg::ErrFin;
        phase_d        = PhDone;
      end
      PhSecond: begin
        mask_d   = b[7];
        mask_new = b[7];
        if (b[6:0] == wsdf_pkg::LenCodeExt64) begin
          emit           = 1'b1;
          res.error_code = wsdf_pkg::ErrLen64;
          phase_d        = PhDone;
        end else if (b[6:0] == wsdf_pkg::LenCodeExt16) begin
          phase_d = PhExtHi;
          emit    = fin_end;
        end else begin
          len_new   = {9'd0, b[6:0]};
          len_d     = len_new;
          after_len = 1'b1;
        end
      end
      PhExtHi: begin
        len_d   = {b, 8'h00};
        phase_d = PhExtLo;
        emit    = fin_end;
      end
      PhExtLo: begin
        len_new   = {len_q[15:8], b};
        len_d     = len_new;
        after_len = 1'b1;
      end
      PhMask: begin
        if (hcnt_q == wsdf_pkg::MaskCntW'(wsdf_pkg::MaskKeyBytes - 1)) begin
          hcnt_d = '0;
          if (len_q == 16'h0000) begin
            phase_d           = PhDone;
            emit              = 1'b1;
            res.kind          = wsdf_pkg::KindEmpty;
            res.last_of_frame = 1'b1;
            res.error_code    = wsdf_pkg::ErrNone;
          end else begin
            phase_d = PhPayload;
            rem_d   = len_q;
            emit    = fin_end;
          end
        end else begin
          hcnt_d = hcnt_q + 1'b1;
          emit   = fin_end;
        end
      end
      PhPayload: begin
        emit = 1'b1;
        if (rem_q <= 16'd1) begin
          rem_d             = 16'h0000;
          phase_d           = PhDone;
          res.kind          = wsdf_pkg::KindData;
          res.payload_byte  = b;
          res.last_of_frame = 1'b1;
          res.error_code    = wsdf_pkg::ErrNone;
        end else if (!fin_end) begin
          rem_d            = rem_q - 16'd1;
          res.kind         = wsdf_pkg::KindData;
          res.payload_byte = b;
          res.error_code   = wsdf_pkg::ErrNone;
        end
      end
      PhDone: begin
      end
      default: begin
      end
    endcase

    // header complete apart from a possible mask key
    if (after_len) begin
      if (mask_new) begin
        phase_d = PhMask;
        hcnt_d  = '0;
        emit    = fin_end;
      end else if (len_new == 16'h0000) begin
        phase_d           = PhDone;
        emit              = 1'b1;
        res.kind          = wsdf_pkg::KindEmpty;
        res.last_of_frame = 1'b1;
        res.error_code    = wsdf_pkg::ErrNone;
      end else begin
        phase_d = PhPayload;
        rem_d   = len_new;
        emit    = fin_end;
      end
    end

    if (fin_end) begin
      phase_d = PhFirst;
      hcnt_d  = '0;
    end
  end

  assign push_o.push = accept && emit;
  assign push_o.item = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhFirst;
      hcnt_q   <= '0;
      opcode_q <= 4'h0;
      mask_q   <= 1'b0;
      len_q    <= 16'h0000;
      rem_q    <= 16'h0000;
    end else if (accept) begin
      phase_q  <= phase_d;
      hcnt_q   <= hcnt_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
    end
  end

endmodule

FILE: sv/wsdf_fifo.sv
`timescale 1ns / 1ps
module wsdf_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wsdf_pkg::push_t  push_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output wsdf_pkg::res_t   head_o
);

  wsdf_pkg::res_t                 mem_q [wsdf_pkg::FifoDepth];
  logic [wsdf_pkg::FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [wsdf_pkg::FifoCntW-1:0]  cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == wsdf_pkg::FifoCntW'(wsdf_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/wsdf_back.sv
`timescale 1ns / 1ps
module wsdf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  wsdf_pkg::res_t  head_i,
  input  logic            out_ready_i,
  output logic            pop_o,
  output logic            out_valid_o,
  output wsdf_pkg::res_t  out_word_o
);

  logic            valid_q;
  wsdf_pkg::res_t  word_q;

  // refill the output register when it is free or being taken
  assign pop_o       = !empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q <= head_i;
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;

  typedef enum logic [2:0] {
    PhFirst, PhSecond, PhFinBad, PhExtHi, PhExtLo, PhMask, PhPayload, PhDone
  } parse_phase_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wsdf_in_if  in_bus ();
  wsdf_out_if out_bus ();

  websocket_frame_deframer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk = ~clk;

  // deframer state as the bench sees it
  parse_phase_e ph = PhFirst;
  logic [2:0]   key_cnt = '0;
  logic [3:0]   fr_opcode = '0;
  logic         fr_masked = 1'b0;
  logic [15:0]  fr_len = '0;
  logic [15:0]  fr_left = '0;

  wsdf_pkg::res_t expected_words[$];
  logic [7:0]     tx_buf[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned fault_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned buffers_sent = 0;
  int unsigned words_checked = 0;
  int unsigned rejects_seen = 0;
  int unsigned empties_seen = 0;
  int unsigned in_stall_cycles = 0;

  function automatic void log_fault(input string msg);
    if (fault_count < 10) $display("%0t: %s", $time, msg);
    fault_count++;
  endfunction

  function automatic void queue_word(input wsdf_pkg::kind_e k, input logic [7:0] pb,
                                     input logic lf, input wsdf_pkg::err_e ec);
    wsdf_pkg::res_t w;
    w.kind = k;
    w.payload_byte = pb;
    w.opcode = fr_opcode;
    w.last_of_frame = lf;
    w.error_code = ec;
    expected_words.push_back(w);
  endfunction

  // length is known: go to the mask key, the payload, or finish an empty frame
  function automatic void enter_body(input logic buf_last);
    if (fr_masked) begin
      ph = PhMask;
      key_cnt = '0;
      if (buf_last) queue_word(wsdf_pkg::KindReject, 8'h00, 1'b0, wsdf_pkg::ErrTrunc);
    end else if (fr_len == 16'd0) begin
      ph = PhDone;
      queue_word(wsdf_pkg::KindEmpty, 8'h00, 1'b1, wsdf_pkg::ErrNone);
    end else begin
      ph = PhPayload;
      fr_left = fr_len;
      if (buf_last) queue_word(wsdf_pkg::KindReject, 8'h00, 1'b0, wsdf_pkg::ErrTrunc);
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic buf_last);
    case (ph)
      PhFirst: begin
        fr_opcode = b[3:0];
        fr_masked = 1'b0;
        fr_len = '0;
        fr_left = '0;
        key_cnt = '0;
        if (buf_last) queue_word(wsdf_pkg::KindReject, 8'h00, 1'b0, wsdf_pkg::ErrTrunc);
        else ph = b[7] ? PhSecond : PhFinBad;
      end
      PhFinBad: begin
        queue_word(wsdf_pkg::KindReject, 8'h00, 1'b0, wsdf_pkg::ErrFin);
        ph = PhDone;
      end
      PhSecond: begin
        fr_masked = b[7];
        if (b[6:0] == wsdf_pkg::LenCodeExt64) begin
          queue_word(wsdf_pkg::KindReject, 8'h00, 1'b0, wsdf_pkg::ErrLen64);
          ph = PhDone;
        end else if (b[6:0] == wsdf_pkg::LenCodeExt16) begin
          ph = PhExtHi;
          if (buf_last) queue_word(wsdf_pkg::KindReject, 8'h00, 1'b0, wsdf_pkg::ErrTrunc);
        end else begin
          fr_len = {9'd0, b[6:0]};
          enter_body(buf_last);
        end
      end
      PhExtHi: begin
        fr_len = {b, 8'h00};
        ph = PhExtLo;
        if (buf_last) queue_word(wsdf_pkg::KindReject, 8'h00, 1'b0, wsdf_pkg::ErrTrunc);
      end
      PhExtLo: begin
        fr_len[7:0] = b;
        enter_body(buf_last);
      end
      PhMask: begin
        key_cnt = key_cnt + 3'd1;
        if (key_cnt >= wsdf_pkg::MaskKeyBytes) begin
          key_cnt = '0;
          if (fr_len == 16'd0) begin
            ph = PhDone;
            queue_word(wsdf_pkg::KindEmpty, 8'h00, 1'b1, wsdf_pkg::ErrNone);
          end else begin
            ph = PhPayload;
            fr_left = fr_len;
            if (buf_last) queue_word(wsdf_pkg::KindReject, 8'h00, 1'b0, wsdf_pkg::ErrTrunc);
          end
        end else if (buf_last) begin
          queue_word(wsdf_pkg::KindReject, 8'h00, 1'b0, wsdf_pkg::ErrTrunc);
        end
      end
      PhPayload: begin
        if (fr_left <= 16'd1) begin
          fr_left = '0;
          ph = PhDone;
          queue_word(wsdf_pkg::KindData, b, 1'b1, wsdf_pkg::ErrNone);
        end else if (buf_last) begin
          // the buffer ran out before the frame did
          queue_word(wsdf_pkg::KindReject, 8'h00, 1'b0, wsdf_pkg::ErrTrunc);
        end else begin
          fr_left = fr_left - 16'd1;
          queue_word(wsdf_pkg::KindData, b, 1'b0, wsdf_pkg::ErrNone);
        end
      end
      default: ;
    endcase
    if (buf_last) begin
      ph = PhFirst;
      key_cnt = '0;
    end
  endfunction

  // called at a rising edge, returns at the edge that accepts the word
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.buffer_end <= is_last;
    do begin
      @(negedge clk);
      took = in_bus.ready;
      @(posedge clk);
      if (!took) in_stall_cycles++;
    end while (!took);
    deframe_byte(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    foreach (tx_buf[i]) send_byte(tx_buf[i], i == tx_buf.size() - 1);
    buffers_sent++;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // header, optional key, body_len bytes of payload and trailer; keep cuts it short
  task automatic build_buffer(input logic fin, input logic [3:0] opc, input logic masked,
                              input logic [6:0] code, input logic [15:0] ext_len,
                              input int unsigned body_len, input int unsigned keep);
    logic [2:0] rsv;
    rsv = 3'($urandom_range(7));
    tx_buf.delete();
    tx_buf.push_back({fin, rsv, opc});
    tx_buf.push_back({masked, code});
    if (code == wsdf_pkg::LenCodeExt16) begin
      tx_buf.push_back(ext_len[15:8]);
      tx_buf.push_back(ext_len[7:0]);
    end
    if (masked) repeat (wsdf_pkg::MaskKeyBytes) tx_buf.push_back(8'($urandom));
    repeat (body_len) tx_buf.push_back(8'($urandom));
    if (keep != 0) while (tx_buf.size() > keep) void'(tx_buf.pop_back());
  endtask

  task automatic random_buffer();
    int unsigned sel;
    int unsigned plen;
    int unsigned keep;
    int unsigned full;
    logic [6:0]  code;
    logic [15:0] ext;
    logic        fin;
    logic        masked;
    sel = $urandom_range(99);
    fin = 1'b1;
    masked = 1'($urandom_range(1));
    ext = '0;
    keep = 0;
    plen = $urandom_range(12);
    code = 7'(plen);
    if (sel < 45) begin
      // short well-formed frame
    end else if (sel < 52) begin
      plen = $urandom_range(125, 100);
      code = 7'(plen);
    end else if (sel < 62) begin
      plen = $urandom_range(40);
      code = wsdf_pkg::LenCodeExt16;
      ext = 16'(plen);
    end else if (sel < 68) begin
      // full 16-bit length, buffer ends early in the payload
      code = wsdf_pkg::LenCodeExt16;
      ext = 16'($urandom);
      plen = $urandom_range(20, 1);
    end else if (sel < 76) begin
      fin = 1'b0;
      code = 7'($urandom_range(127));
    end else if (sel < 82) begin
      code = wsdf_pkg::LenCodeExt64;
    end else begin
      if ($urandom_range(1) == 1) begin
        code = wsdf_pkg::LenCodeExt16;
        ext = 16'(plen);
      end
      full = 2 + ((code == wsdf_pkg::LenCodeExt16) ? 2 : 0)
             + (masked ? wsdf_pkg::MaskKeyBytes : 0) + plen;
      keep = $urandom_range(full - 1, 1);
    end
    if (sel < 62 && $urandom_range(3) == 0) plen += $urandom_range(3, 1);
    build_buffer(fin, 4'($urandom_range(15)), masked, code, ext, plen, keep);
    send_buffer();
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // one-byte buffer with fin clear
    tx_buf = '{8'h01};
    send_buffer();
    // fin clear, rejected on the second byte even though it ends the buffer
    tx_buf = '{8'h02, 8'h85};
    send_buffer();
    // 64-bit length code with mask bit
    tx_buf = '{8'h81, 8'hFF};
    send_buffer();
    // ends on the 16-bit length code, then inside the extended length
    tx_buf = '{8'h81, 8'h7E};
    send_buffer();
    tx_buf = '{8'hF1, 8'h7E, 8'h00};
    send_buffer();
    // ends inside the mask key
    tx_buf = '{8'h82, 8'h81, 8'hAA};
    send_buffer();
    // ends inside the payload after one byte went out
    tx_buf = '{8'h81, 8'h03, 8'h11, 8'h22};
    send_buffer();
    // extended length of zero is an empty frame
    tx_buf = '{8'h89, 8'h7E, 8'h00, 8'h00};
    send_buffer();
    // empty frame with a trailer
    tx_buf = '{8'h8A, 8'h00, 8'h33};
    send_buffer();
    // masked, opcode 15, byte extremes, trailer ignored
    tx_buf = '{8'h8F, 8'h82, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55};
    send_buffer();
    // single payload byte on the buffer's last byte
    tx_buf = '{8'h80, 8'h01, 8'hFF};
    send_buffer();
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 120;
    build_buffer(1'b1, 4'h2, 1'b0, 7'd60, 16'd0, 60, 0);
    send_buffer();
    drain();
  endtask

  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned n_bytes);
    int unsigned stop_at;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) random_buffer();
    drain();
  endtask

  // receiver: long hold-off when asked, random stalls otherwise
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker: sample mid-cycle, act on the following edge
  initial begin
    wsdf_pkg::res_t got;
    wsdf_pkg::res_t want;
    logic seen;
    forever begin
      @(negedge clk);
      seen = rst_n && out_bus.valid && out_bus.ready;
      got.kind = wsdf_pkg::kind_e'(out_bus.kind);
      got.payload_byte = out_bus.payload_byte;
      got.opcode = out_bus.opcode;
      got.last_of_frame = out_bus.last_of_frame;
      got.error_code = wsdf_pkg::err_e'(out_bus.error_code);
      @(posedge clk);
      if (seen) begin
        if (expected_words.size() == 0) begin
          log_fault($sformatf("unexpected word kind=%0d byte=%02h op=%0h last=%0b err=%0d",
                              got.kind, got.payload_byte, got.opcode,
                              got.last_of_frame, got.error_code));
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (got.kind == wsdf_pkg::KindReject) rejects_seen++;
          if (got.kind == wsdf_pkg::KindEmpty) empties_seen++;
          if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
              got.opcode !== want.opcode ||
              got.last_of_frame !== want.last_of_frame ||
              got.error_code !== want.error_code) begin
            log_fault($sformatf({"word %0d: expected kind=%0d byte=%02h op=%0h last=%0b ",
                                 "err=%0d, got kind=%0d byte=%02h op=%0h last=%0b err=%0d"},
                                words_checked, want.kind, want.payload_byte,
                                want.opcode, want.last_of_frame, want.error_code,
                                got.kind, got.payload_byte, got.opcode,
                                got.last_of_frame, got.error_code));
          end
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("tb failed");
    $finish;
  end

  initial begin
    int unsigned waited;
    in_bus.valid = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.buffer_end = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(0, 0, 300);
    test_random(48, 0, 300);
    test_random(0, 48, 300);
    test_random(6, 6, 300);

    recv_stall_pct = 0;
    waited = 0;
    while (expected_words.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_words.size() != 0)
      log_fault($sformatf("%0d expected words never arrived", expected_words.size()));

    $display("sent %0d bytes in %0d buffers; checked %0d words (%0d rejections, %0d empty)",
             bytes_sent, buffers_sent, words_checked, rejects_seen, empties_seen);
    $display("input held off for %0d cycles; %0d faults", in_stall_cycles, fault_count);
    if (fault_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/wsdf_pkg.sv
sv/wsdf_if.sv
sv/wsdf_front.sv
sv/wsdf_fifo.sv
sv/wsdf_back.sv
sv/websocket_frame_deframer.sv
bench/tb.sv
